// ===== rtl/core/prnt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// prnt_pkg
// Shared widths, status codes and transaction types of the packet
// reassembly tracker.
// ----------------------------------------------------------------------------
package prnt_pkg;

  localparam int MAX_PACKETS_DEF   = 4096;
  localparam int NACK_MAX_DEF      = 32;
  localparam int PAYLOAD_BYTES_DEF = 1016;

  localparam int SEQ_W     = 12;
  localparam int FS_W      = 22;
  localparam int OFF_W     = 22;
  localparam int LEN_W     = 10;
  localparam int PLEN_W    = 16;   // full payload length, up to 65535
  localparam int PROD_W    = SEQ_W + PLEN_W;
  localparam int STATUS_W  = 3;
  localparam int BYTES_W   = 23;
  localparam int NUM_W     = 23;   // file_size + payload - 1
  localparam int ROW_BITS  = 32;
  localparam int FOUND_W   = 6;
  localparam int RESULT_CAP = 32;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  localparam logic [FS_W-1:0]    FILE_SIZE_RST = 22'd1;
  localparam logic [BYTES_W-1:0] BYTES_SAT     = 23'h7F_FFFF;

  localparam logic [STATUS_W-1:0] ST_ACCEPTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_OUT_RANGE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_MISSING   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NONE_MISS = 3'd4;
  localparam logic [STATUS_W-1:0] ST_CLOSED    = 3'd5;

  localparam logic REQ_PACKET  = 1'b0;
  localparam logic REQ_TIMEOUT = 1'b1;

  // classified transaction waiting for the back end
  typedef struct packed {
    logic              req_type;
    logic [SEQ_W-1:0]  seq;
    logic              in_range;
    logic [OFF_W-1:0]  off;
    logic [PLEN_W-1:0] len;
  } prnt_entry_t;

  typedef struct packed {
    logic                strobe;
    logic [STATUS_W-1:0] status;
    logic [OFF_W-1:0]    write_offset;
    logic [LEN_W-1:0]    write_length;
    logic                transfer_done;
    logic [SEQ_W-1:0]    missing_seq;
    logic                last;
  } prnt_result_t;

endpackage
`default_nettype wire

// ===== rtl/core/packet_reassembly_nack_tracker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// packet_reassembly_nack_tracker
// Receive-side tracker: received bitmap, byte count and missing-packet list.
// ----------------------------------------------------------------------------
// Results leave on out_strobe for one cycle each and cannot be held off.
// A packet transaction gives its single result on the outputs after the
// front stage, the queue, the bitmap row read and the result register;
// packets are limited by the read-modify-write of one 32-bit bitmap row.
// A timeout works out the packet count by a constant reciprocal multiply,
// then reads, loads and scans each bitmap row up to that count, reporting
// one missing entry per step, sees the end of the scan and gives the final
// result; a full report ends the scan early. After reset busy stays high
// while the bitmap is swept clear, one row at a time (128 rows at the
// default size). Four classified transactions can queue up in front of
// the back end, so new ones are taken while earlier ones are worked on.
// ----------------------------------------------------------------------------
module packet_reassembly_nack_tracker #(
  parameter int MAX_PACKETS   = prnt_pkg::MAX_PACKETS_DEF,
  parameter int NACK_MAX      = prnt_pkg::NACK_MAX_DEF,
  parameter int PAYLOAD_BYTES = prnt_pkg::PAYLOAD_BYTES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          in_req_type,
  input  wire logic [prnt_pkg::SEQ_W-1:0]    in_seq_num,
  input  wire logic                          cfg_wr_en,
  input  wire logic [prnt_pkg::FS_W-1:0]     cfg_file_size,
  output logic                               out_strobe,
  output logic [prnt_pkg::STATUS_W-1:0]      out_status,
  output logic [prnt_pkg::OFF_W-1:0]         out_write_offset,
  output logic [prnt_pkg::LEN_W-1:0]         out_write_length,
  output logic                               out_transfer_done,
  output logic [prnt_pkg::SEQ_W-1:0]         out_missing_seq,
  output logic                               out_last
);
  import prnt_pkg::*;

  logic [FS_W-1:0]   fs_r, fs_nxt;
  logic              accept;
  logic              stage_valid;
  logic              push;
  prnt_entry_t       entry;
  prnt_entry_t       q_head;
  logic              q_empty;
  logic [QCNT_W-1:0] q_count;
  logic              q_pop;
  logic              clearing;
  prnt_result_t      result;

  assign fs_nxt = cfg_wr_en ? cfg_file_size : fs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fs_r <= FILE_SIZE_RST;
    end else begin
      fs_r <= fs_nxt;
    end
  end

  // leave room for the transaction sitting in the front stage
  assign busy   = clearing ||
                  ((q_count + QCNT_W'(stage_valid)) >= QCNT_W'(QUEUE_DEPTH));
  assign accept = start && !busy;

  prnt_front #(
    .MAX_PACKETS   (MAX_PACKETS),
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .req_type    (in_req_type),
    .seq_num     (in_seq_num),
    .file_size   (fs_r),
    .stage_valid (stage_valid),
    .push        (push),
    .entry       (entry)
  );

  prnt_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (entry),
    .pop   (q_pop),
    .dout  (q_head),
    .empty (q_empty),
    .count (q_count)
  );

  prnt_back #(
    .MAX_PACKETS   (MAX_PACKETS),
    .NACK_MAX      (NACK_MAX),
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .file_size (fs_r),
    .q_head    (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .clearing  (clearing),
    .result    (result)
  );

  assign out_strobe        = result.strobe;
  assign out_status        = result.status;
  assign out_write_offset  = result.write_offset;
  assign out_write_length  = result.write_length;
  assign out_transfer_done = result.transfer_done;
  assign out_missing_seq   = result.missing_seq;
  assign out_last          = result.last;

endmodule
`default_nettype wire

// ===== rtl/core/prnt_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// prnt_front
// Takes a transaction, forms the byte offset, then checks range and
// payload length and pushes the classified entry to the queue.
// ----------------------------------------------------------------------------
module prnt_front #(
  parameter int MAX_PACKETS   = prnt_pkg::MAX_PACKETS_DEF,
  parameter int PAYLOAD_BYTES = prnt_pkg::PAYLOAD_BYTES_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        accept,
  input  wire logic                        req_type,
  input  wire logic [prnt_pkg::SEQ_W-1:0]  seq_num,
  input  wire logic [prnt_pkg::FS_W-1:0]   file_size,
  output logic                             stage_valid,
  output logic                             push,
  output prnt_pkg::prnt_entry_t            entry
);
  import prnt_pkg::*;

  localparam logic [PLEN_W-1:0] PAY16 = PLEN_W'(PAYLOAD_BYTES);

  logic              f_v_r,    f_v_nxt;
  logic              f_type_r;
  logic [SEQ_W-1:0]  f_seq_r;
  logic [PROD_W-1:0] f_prod_r;
  logic [FS_W-1:0]   diff;

  assign f_v_nxt = accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else begin
      f_v_r <= f_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_type_r <= req_type;
      f_seq_r  <= seq_num;
      f_prod_r <= PROD_W'(seq_num) * PROD_W'(PAY16);
    end
  end

  assign diff = file_size - f_prod_r[FS_W-1:0];

  always_comb begin
    entry.req_type = f_type_r;
    entry.seq      = f_seq_r;
    // seq < ceil(file_size / payload) is the same as seq * payload < file_size
    entry.in_range = (f_prod_r < PROD_W'(file_size)) &&
                     (32'(f_seq_r) < 32'(MAX_PACKETS));
    entry.off      = f_prod_r[OFF_W-1:0];
    entry.len      = (diff > FS_W'(PAY16)) ? PAY16 : diff[PLEN_W-1:0];
  end

  assign push        = f_v_r;
  assign stage_valid = f_v_r;

endmodule
`default_nettype wire

// ===== rtl/core/prnt_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// prnt_queue
// Short FIFO of classified transactions between front and back end.
// ----------------------------------------------------------------------------
module prnt_queue (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        push,
  input  wire prnt_pkg::prnt_entry_t       din,
  input  wire logic                        pop,
  output prnt_pkg::prnt_entry_t            dout,
  output logic                             empty,
  output logic [prnt_pkg::QCNT_W-1:0]      count
);
  import prnt_pkg::*;

  prnt_entry_t       slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wp_r,  wp_nxt;
  logic [QPTR_W-1:0] rp_r,  rp_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_pop;

  assign do_pop = pop && (cnt_r != '0);

  always_comb begin
    wp_nxt  = push   ? wp_r + 1'b1 : wp_r;
    rp_nxt  = do_pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r;
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= din;
    end
  end

  assign dout  = slot_r[rp_r];
  assign empty = (cnt_r == '0);
  assign count = cnt_r;

endmodule
`default_nettype wire

// ===== rtl/core/prnt_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// prnt_back
// Owns the received bitmap and byte count. Marks packets, and on a
// timeout works out the packet count by a constant reciprocal multiply,
// then walks the bitmap a row at a time listing missing numbers.
// ----------------------------------------------------------------------------
module prnt_back #(
  parameter int MAX_PACKETS   = prnt_pkg::MAX_PACKETS_DEF,
  parameter int NACK_MAX      = prnt_pkg::NACK_MAX_DEF,
  parameter int PAYLOAD_BYTES = prnt_pkg::PAYLOAD_BYTES_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [prnt_pkg::FS_W-1:0]   file_size,
  input  wire prnt_pkg::prnt_entry_t       q_head,
  input  wire logic                        q_empty,
  output logic                             q_pop,
  output logic                             clearing,
  output prnt_pkg::prnt_result_t           result
);
  import prnt_pkg::*;

  localparam int NROWS  = (MAX_PACKETS + ROW_BITS - 1) / ROW_BITS;
  localparam int ROW_AW = (NROWS > 1) ? $clog2(NROWS) : 1;
  localparam int CMP_W  = ROW_AW + 6;
  localparam int LIMIT  = (NACK_MAX < RESULT_CAP) ? NACK_MAX : RESULT_CAP;

  // floor(n / payload) == (n * RCP) >> RCP_K for every n below 2^NUM_W
  localparam int RCP_L  = $clog2(PAYLOAD_BYTES);
  localparam int RCP_K  = NUM_W + RCP_L;
  localparam int RCP_W  = NUM_W + 1;
  localparam int PROD2_W = NUM_W + RCP_W;
  localparam longint unsigned RCP_M =
    ((64'd1 << RCP_K) + 64'(PAYLOAD_BYTES) - 64'd1) / 64'(PAYLOAD_BYTES);

  localparam logic [PLEN_W:0]      PAY17   = (PLEN_W+1)'(PAYLOAD_BYTES);
  localparam logic [RCP_W-1:0]     RCP     = RCP_W'(RCP_M);
  localparam logic [NUM_W-1:0]     MAXQ    = NUM_W'(MAX_PACKETS);
  localparam logic [ROW_AW-1:0]    LASTROW = ROW_AW'(NROWS - 1);
  localparam logic [FOUND_W-1:0]   LIMITF  = FOUND_W'(LIMIT);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_PKT_CHK   = 3'd1;
  localparam logic [2:0] S_DIV       = 3'd2;
  localparam logic [2:0] S_SCAN_RD   = 3'd3;
  localparam logic [2:0] S_SCAN_LOAD = 3'd4;
  localparam logic [2:0] S_SCAN_BITS = 3'd5;
  localparam logic [2:0] S_FIN       = 3'd6;
  localparam logic [2:0] S_QUO       = 3'd7;

  logic [ROW_BITS-1:0] mem [NROWS];

  logic [2:0]          state_r,  state_nxt;
  prnt_entry_t         cur_r,    cur_nxt;
  logic [ROW_BITS-1:0] rd_data_r;
  logic [BYTES_W-1:0]  rb_r,     rb_nxt;
  logic                closed_r, closed_nxt;
  logic                clr_r,    clr_nxt;
  logic [ROW_AW-1:0]   clr_row_r, clr_row_nxt;
  logic [NUM_W-1:0]    num_r,    num_nxt;
  logic [PROD2_W-1:0]  prod_r,   prod_nxt;
  logic [CMP_W-1:0]    total_r,  total_nxt;
  logic [ROW_AW:0]     row_r,    row_nxt;
  logic [ROW_BITS-1:0] cand_r,   cand_nxt;
  logic [SEQ_W-1:0]    pend_r,   pend_nxt;
  logic                pend_v_r, pend_v_nxt;
  logic [FOUND_W-1:0]  found_r,  found_nxt;
  prnt_result_t        res_r,    res_nxt;

  logic                re, we;
  logic [ROW_AW-1:0]   ra, wa;
  logic [ROW_BITS-1:0] wd;

  logic [ROW_AW+16:0]  seq_x, cur_x, ix_x;
  logic [NUM_W-1:0]    quo, quo_cap;
  logic [CMP_W-1:0]    base, rem_rows;
  logic [ROW_BITS-1:0] lim_mask;
  logic [4:0]          fb;
  logic [BYTES_W:0]    sum;
  logic [BYTES_W-1:0]  sum_sat;

  assign seq_x = {{(ROW_AW+5){1'b0}}, q_head.seq};
  assign cur_x = {{(ROW_AW+5){1'b0}}, cur_r.seq};
  assign base  = {row_r, 5'd0};
  assign ix_x  = {12'd0, row_r[ROW_AW-1:0], fb};

  assign quo     = NUM_W'(prod_r >> RCP_K);
  assign quo_cap = (quo > MAXQ) ? MAXQ : quo;

  assign rem_rows = total_r - base;
  assign lim_mask = (rem_rows >= CMP_W'(ROW_BITS)) ? '1 :
                    ({ROW_BITS{1'b1}} >> (6'd32 - rem_rows[5:0]));

  always_comb begin
    fb = '0;
    for (int i = ROW_BITS - 1; i >= 0; i--) begin
      if (cand_r[i]) begin
        fb = 5'(i);
      end
    end
  end

  assign sum     = {1'b0, rb_r} + (BYTES_W+1)'(cur_r.len);
  assign sum_sat = (sum > {1'b0, BYTES_SAT}) ? BYTES_SAT : sum[BYTES_W-1:0];

  always_comb begin
    state_nxt   = state_r;
    cur_nxt     = cur_r;
    rb_nxt      = rb_r;
    closed_nxt  = closed_r;
    clr_nxt     = clr_r;
    clr_row_nxt = clr_row_r;
    num_nxt     = num_r;
    prod_nxt    = prod_r;
    total_nxt   = total_r;
    row_nxt     = row_r;
    cand_nxt    = cand_r;
    pend_nxt    = pend_r;
    pend_v_nxt  = pend_v_r;
    found_nxt   = found_r;
    res_nxt     = '0;
    q_pop       = 1'b0;
    re          = 1'b0;
    ra          = '0;
    we          = 1'b0;
    wa          = '0;
    wd          = '0;

    if (clr_r) begin
      // sweep the bitmap clear after reset
      we          = 1'b1;
      wa          = clr_row_r;
      clr_row_nxt = clr_row_r + 1'b1;
      if (clr_row_r == LASTROW) begin
        clr_nxt = 1'b0;
      end
    end else begin
      case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            q_pop   = 1'b1;
            cur_nxt = q_head;
            if (closed_r) begin
              res_nxt.strobe        = 1'b1;
              res_nxt.status        = ST_CLOSED;
              res_nxt.transfer_done = 1'b1;
              res_nxt.last          = 1'b1;
            end else if (q_head.req_type == REQ_TIMEOUT) begin
              num_nxt     = NUM_W'(file_size) + NUM_W'(PAY17) - 1'b1;
              pend_v_nxt  = 1'b0;
              found_nxt   = '0;
              row_nxt     = '0;
              state_nxt   = S_DIV;
            end else if (!q_head.in_range) begin
              res_nxt.strobe = 1'b1;
              res_nxt.status = ST_OUT_RANGE;
              res_nxt.last   = 1'b1;
            end else begin
              re        = 1'b1;
              ra        = seq_x[ROW_AW+4:5];
              state_nxt = S_PKT_CHK;
            end
          end
        end
        S_PKT_CHK: begin
          res_nxt.strobe = 1'b1;
          res_nxt.last   = 1'b1;
          if (rd_data_r[cur_r.seq[4:0]]) begin
            res_nxt.status = ST_DUPLICATE;
          end else begin
            we     = 1'b1;
            wa     = cur_x[ROW_AW+4:5];
            wd     = rd_data_r | (ROW_BITS'(1) << cur_r.seq[4:0]);
            rb_nxt = sum_sat;
            res_nxt.status       = ST_ACCEPTED;
            res_nxt.write_offset = cur_r.off;
            res_nxt.write_length = LEN_W'(cur_r.len);
            if (sum_sat >= BYTES_W'(file_size)) begin
              closed_nxt            = 1'b1;
              res_nxt.transfer_done = 1'b1;
            end
          end
          state_nxt = S_IDLE;
        end
        S_DIV: begin
          prod_nxt  = {{RCP_W{1'b0}}, num_r} * {{NUM_W{1'b0}}, RCP};
          state_nxt = S_QUO;
        end
        S_QUO: begin
          total_nxt = CMP_W'(quo_cap);
          state_nxt = S_SCAN_RD;
        end
        S_SCAN_RD: begin
          if (base < total_r) begin
            re        = 1'b1;
            ra        = row_r[ROW_AW-1:0];
            state_nxt = S_SCAN_LOAD;
          end else begin
            state_nxt = S_FIN;
          end
        end
        S_SCAN_LOAD: begin
          cand_nxt  = ~rd_data_r & lim_mask;
          state_nxt = S_SCAN_BITS;
        end
        S_SCAN_BITS: begin
          if (cand_r == '0) begin
            row_nxt   = row_r + 1'b1;
            state_nxt = S_SCAN_RD;
          end else begin
            // hold one found entry back so the final one can carry last
            cand_nxt = cand_r & ~(ROW_BITS'(1) << fb);
            if (pend_v_r) begin
              res_nxt.strobe      = 1'b1;
              res_nxt.status      = ST_MISSING;
              res_nxt.missing_seq = pend_r;
            end
            pend_nxt   = ix_x[SEQ_W-1:0];
            pend_v_nxt = 1'b1;
            found_nxt  = found_r + 1'b1;
            if (found_r + 1'b1 == LIMITF) begin
              state_nxt = S_FIN;
            end
          end
        end
        S_FIN: begin
          res_nxt.strobe = 1'b1;
          res_nxt.last   = 1'b1;
          if (pend_v_r) begin
            res_nxt.status      = ST_MISSING;
            res_nxt.missing_seq = pend_r;
          end else begin
            res_nxt.status = ST_NONE_MISS;
          end
          pend_v_nxt = 1'b0;
          state_nxt  = S_IDLE;
        end
        default: begin
          state_nxt = S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      rb_r      <= '0;
      closed_r  <= 1'b0;
      clr_r     <= 1'b1;
      clr_row_r <= '0;
      pend_v_r  <= 1'b0;
      found_r   <= '0;
      res_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      rb_r      <= rb_nxt;
      closed_r  <= closed_nxt;
      clr_r     <= clr_nxt;
      clr_row_r <= clr_row_nxt;
      pend_v_r  <= pend_v_nxt;
      found_r   <= found_nxt;
      res_r     <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r     <= cur_nxt;
    num_r     <= num_nxt;
    prod_r    <= prod_nxt;
    total_r   <= total_nxt;
    row_r     <= row_nxt;
    cand_r    <= cand_nxt;
    pend_r    <= pend_nxt;
  end

  // bitmap: one write and one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_data_r <= mem[ra];
    end
  end

  assign clearing = clr_r;
  assign result   = res_r;

endmodule
`default_nettype wire

// ===== bench/packet_reassembly_nack_tracker_checker.sv =====
// ----------------------------------------------------------------------------
// packet_reassembly_nack_tracker_checker
// Watches the command, configuration and result ports of the tracker. It
// keeps its own bitmap, byte count and closed flag and works out the
// results of every accepted transaction. Each strobed result is compared
// field by field with the oldest outstanding one.
// ----------------------------------------------------------------------------
module packet_reassembly_nack_tracker_checker (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic                          busy,
  input  wire logic                          in_req_type,
  input  wire logic [prnt_pkg::SEQ_W-1:0]    in_seq_num,
  input  wire logic                          cfg_wr_en,
  input  wire logic [prnt_pkg::FS_W-1:0]     cfg_file_size,
  input  wire logic                          out_strobe,
  input  wire logic [prnt_pkg::STATUS_W-1:0] out_status,
  input  wire logic [prnt_pkg::OFF_W-1:0]    out_write_offset,
  input  wire logic [prnt_pkg::LEN_W-1:0]    out_write_length,
  input  wire logic                          out_transfer_done,
  input  wire logic [prnt_pkg::SEQ_W-1:0]    out_missing_seq,
  input  wire logic                          out_last,
  output int                                 fail_count,
  output int                                 pending_count
);
  import prnt_pkg::*;

  localparam int unsigned PAYLOAD  = PAYLOAD_BYTES_DEF;
  localparam int unsigned PKT_CAP  = MAX_PACKETS_DEF;
  localparam int unsigned NACK_CAP = (NACK_MAX_DEF < RESULT_CAP) ? NACK_MAX_DEF : RESULT_CAP;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [OFF_W-1:0]    offset;
    logic [LEN_W-1:0]    length;
    logic                done;
    logic [SEQ_W-1:0]    miss;
    logic                last;
  } outcome_t;

  outcome_t           awaited[$];
  bit                 received [PKT_CAP];
  logic [BYTES_W-1:0] byte_count;
  bit                 closed;
  logic [FS_W-1:0]    file_size;
  int                 errors_seen = 0;
  int                 queued = 0;

  assign fail_count    = errors_seen;
  assign pending_count = queued;

  function automatic outcome_t outcome(logic [STATUS_W-1:0] st, int unsigned off,
                                       int unsigned len, bit done, int unsigned miss,
                                       bit last);
    outcome_t o;
    o.status = st;
    o.offset = off[OFF_W-1:0];
    o.length = len[LEN_W-1:0];
    o.done   = done;
    o.miss   = miss[SEQ_W-1:0];
    o.last   = last;
    return o;
  endfunction

  task automatic predict_transaction(input logic req, input logic [SEQ_W-1:0] seq);
    int unsigned npkt;
    int unsigned off;
    int unsigned len;
    int unsigned sum;
    int unsigned holes [NACK_CAP];
    int unsigned nfound;
    bit          done;
    npkt = (32'(file_size) + PAYLOAD - 1) / PAYLOAD;
    if (npkt > PKT_CAP) npkt = PKT_CAP;
    nfound = 0;
    done = 0;
    if (closed) begin
      awaited.push_back(outcome(ST_CLOSED, 0, 0, 1, 0, 1));
    end else if (req == REQ_PACKET) begin
      if (32'(seq) >= npkt) begin
        awaited.push_back(outcome(ST_OUT_RANGE, 0, 0, 0, 0, 1));
      end else if (received[seq]) begin
        awaited.push_back(outcome(ST_DUPLICATE, 0, 0, 0, 0, 1));
      end else begin
        received[seq] = 1'b1;
        off = 32'(seq) * PAYLOAD;
        len = 32'(file_size) - off;
        if (len > PAYLOAD) len = PAYLOAD;
        sum = 32'(byte_count) + len;
        if (sum > 32'(BYTES_SAT)) sum = 32'(BYTES_SAT);
        byte_count = sum[BYTES_W-1:0];
        if (sum >= 32'(file_size)) begin
          closed = 1'b1;
          done = 1'b1;
        end
        awaited.push_back(outcome(ST_ACCEPTED, off, len, done, 0, 1));
      end
    end else begin
      // scan stops as soon as the report is full
      for (int unsigned i = 0; i < npkt && nfound < NACK_CAP; i++) begin
        if (!received[i]) begin
          holes[nfound] = i;
          nfound++;
        end
      end
      if (nfound == 0) begin
        awaited.push_back(outcome(ST_NONE_MISS, 0, 0, 0, 0, 1));
      end else begin
        for (int unsigned k = 0; k < nfound; k++)
          awaited.push_back(outcome(ST_MISSING, 0, 0, 0, holes[k], k == nfound - 1));
      end
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors_seen++;
    end
  endtask

  task automatic check_result();
    outcome_t want;
    if (awaited.size() == 0) begin
      $error("result with status %0d but no transaction outstanding", out_status);
      errors_seen++;
    end else begin
      want = awaited.pop_front();
      compare_field("status", 32'(want.status), 32'(out_status));
      compare_field("write_offset", 32'(want.offset), 32'(out_write_offset));
      compare_field("write_length", 32'(want.length), 32'(out_write_length));
      compare_field("transfer_done", 32'(want.done), 32'(out_transfer_done));
      compare_field("missing_seq", 32'(want.miss), 32'(out_missing_seq));
      compare_field("last", 32'(want.last), 32'(out_last));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (received[i]) received[i] = 1'b0;
      byte_count = '0;
      closed = 1'b0;
      file_size = FILE_SIZE_RST;
      awaited.delete();
    end else begin
      if (out_strobe) check_result();
      if (cfg_wr_en) file_size = cfg_file_size;
      if (start && !busy) predict_transaction(in_req_type, in_seq_num);
    end
    queued <= awaited.size();
  end

endmodule

// ===== bench/packet_reassembly_nack_tracker_test.sv =====
// ----------------------------------------------------------------------------
// packet_reassembly_nack_tracker_test
// Drives packet and timeout transactions and file size writes into the
// tracker: a directed pass over the corner cases, random rounds at large
// file sizes, and a final completion of a small file. Checking is left to
// the checker instance; this module gives the verdict.
// ----------------------------------------------------------------------------
module packet_reassembly_nack_tracker_test;
  import prnt_pkg::*;

  localparam int unsigned PAYLOAD = PAYLOAD_BYTES_DEF;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                in_req_type;
  logic [SEQ_W-1:0]    in_seq_num;
  logic                cfg_wr_en;
  logic [FS_W-1:0]     cfg_file_size;
  wire                 busy;
  wire                 out_strobe;
  wire [STATUS_W-1:0]  out_status;
  wire [OFF_W-1:0]     out_write_offset;
  wire [LEN_W-1:0]     out_write_length;
  wire                 out_transfer_done;
  wire [SEQ_W-1:0]     out_missing_seq;
  wire                 out_last;
  int                  fail_count;
  int                  pending_count;

  packet_reassembly_nack_tracker uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_req_type      (in_req_type),
    .in_seq_num       (in_seq_num),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_file_size    (cfg_file_size),
    .out_strobe       (out_strobe),
    .out_status       (out_status),
    .out_write_offset (out_write_offset),
    .out_write_length (out_write_length),
    .out_transfer_done(out_transfer_done),
    .out_missing_seq  (out_missing_seq),
    .out_last         (out_last)
  );

  packet_reassembly_nack_tracker_checker chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_req_type      (in_req_type),
    .in_seq_num       (in_seq_num),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_file_size    (cfg_file_size),
    .out_strobe       (out_strobe),
    .out_status       (out_status),
    .out_write_offset (out_write_offset),
    .out_write_length (out_write_length),
    .out_transfer_done(out_transfer_done),
    .out_missing_seq  (out_missing_seq),
    .out_last         (out_last),
    .fail_count       (fail_count),
    .pending_count    (pending_count)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #10_000_000;
    $display("packet_reassembly_nack_tracker_test: done, errors");
    $finish;
  end

  // start stays high across back-to-back transactions
  task automatic send_request(input logic req, input logic [SEQ_W-1:0] seq);
    @(negedge clk);
    start <= 1'b1;
    in_req_type <= req;
    in_seq_num <= seq;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic hold_off(input int unsigned cycles);
    @(negedge clk);
    start <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_file_size(input logic [FS_W-1:0] size);
    settle();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_file_size <= size;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    logic [FS_W-1:0]  fs;
    logic [SEQ_W-1:0] seq;
    int unsigned      npkt;
    int unsigned      pick;
    bit               gaps_on;

    rst_n = 1'b0;
    start = 1'b0;
    in_req_type = REQ_PACKET;
    in_seq_num = '0;
    cfg_wr_en = 1'b0;
    cfg_file_size = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset size of one byte: only packet 0 exists, leave it unsent
    send_request(REQ_TIMEOUT, 12'hFFF);
    send_request(REQ_PACKET, 12'd1);

    // empty file
    set_file_size(22'd0);
    send_request(REQ_PACKET, 12'd0);
    send_request(REQ_PACKET, 12'hFFF);
    send_request(REQ_TIMEOUT, 12'd0);

    // top of range, last packet is one byte short
    set_file_size(22'd4161535);
    send_request(REQ_PACKET, 12'hFFF);
    send_request(REQ_PACKET, 12'd0);
    send_request(REQ_PACKET, 12'd0);
    send_request(REQ_TIMEOUT, 12'hFFF);

    // widest size, packet count capped
    set_file_size(22'h3FFFFF);
    send_request(REQ_PACKET, 12'hFFE);
    send_request(REQ_PACKET, 12'd1);
    send_request(REQ_PACKET, 12'd2);
    send_request(REQ_PACKET, 12'd3);
    send_request(REQ_PACKET, 12'hFFF);
    send_request(REQ_TIMEOUT, 12'h555);

    // exact multiple, all four packets already held
    set_file_size(22'(4 * PAYLOAD));
    send_request(REQ_TIMEOUT, 12'hAAA);
    send_request(REQ_PACKET, 12'd3);
    send_request(REQ_PACKET, 12'd4);

    set_file_size(22'd1);
    send_request(REQ_PACKET, 12'd0);
    send_request(REQ_PACKET, 12'd1);
    send_request(REQ_TIMEOUT, 12'd0);

    // sizes stay far above the byte count so the file never completes here;
    // packets 4..15 are kept back for the final completion
    gaps_on = 1'b0;
    for (int round = 0; round < 5; round++) begin
      fs = (round == 0) ? 22'h3FFFFF : 22'($urandom_range(2_000_000, 4_161_535));
      set_file_size(fs);
      npkt = (32'(fs) + PAYLOAD - 1) / PAYLOAD;
      if (npkt > MAX_PACKETS_DEF) npkt = MAX_PACKETS_DEF;
      for (int k = 0; k < 25; k++) begin
        if (k % 10 == 0) gaps_on = ($urandom_range(0, 2) != 0);
        if (gaps_on && $urandom_range(0, 2) == 0) hold_off($urandom_range(1, 8));
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
          send_request(REQ_TIMEOUT, 12'($urandom));
        end else begin
          if (pick < 65) seq = 12'($urandom_range(16, 143));
          else if (pick < 85) begin
            seq = 12'($urandom_range(0, 4095));
            if (seq >= 4 && seq < 16) seq = seq + 12'd16;
          end else if (pick < 93) seq = 12'(npkt - 1);
          else seq = 12'($urandom_range(4080, 4095));
          send_request(REQ_PACKET, seq);
        end
      end
    end

    // six packets, 0..3 held; packet 5 carries the remainder and completes
    fs = 22'(5 * PAYLOAD + $urandom_range(1, PAYLOAD - 1));
    set_file_size(fs);
    send_request(REQ_TIMEOUT, 12'd0);
    send_request(REQ_PACKET, 12'd6);
    send_request(REQ_PACKET, 12'd0);
    send_request(REQ_PACKET, 12'd5);
    send_request(REQ_PACKET, 12'd4);
    send_request(REQ_TIMEOUT, 12'd0);
    send_request(REQ_PACKET, 12'd0);

    settle();
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending_count == 0)
      $display("packet_reassembly_nack_tracker_test: done, clean");
    else
      $display("packet_reassembly_nack_tracker_test: done, errors");
    $finish;
  end

endmodule
